[rtl/bitmap_page_allocator_top_assert.svh]
// Assertion macros for the bitmap page allocator.
// Used by the top level; no other dependencies.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define BPA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[rtl/bpa_pkg.sv]
// Package for the bitmap page allocator: payload types, codes, constants.
// No dependencies.
package bpa_pkg;
	localparam int MAP_WORDS_DEF = 1024;

	localparam logic [2:0] CMD_ALLOC_ONE  = 3'd0;
	localparam logic [2:0] CMD_ALLOC_RUN  = 3'd1;
	localparam logic [2:0] CMD_FREE       = 3'd2;
	localparam logic [2:0] CMD_MARK_FREE  = 3'd3;
	localparam logic [2:0] CMD_MARK_USED  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [14:0] page;
		logic [15:0] count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] page_out;
	} rsp_t;
endpackage

[rtl/bitmap_page_allocator_top.sv]
// Bitmap page allocator top level: sequencer around one bitmap memory.
// Depends on bpa_pkg and bitmap_page_allocator_top_assert.svh.
//
// One request is handled at a time. A new request is taken only once the
// previous result has been transferred. After reset a clearing pass writes
// every bitmap word to all-used, during which req_ready is low. Alloc one
// reads and evaluates one word at a time and stops at the first word with a
// free bit. Alloc run reads a word and then checks one page per cycle,
// rereading on each word change, from page 0 until the run is found or the
// last page is reached. It then marks the run page by page, a read and a
// write-back each. Free and range commands do a read-modify-write per
// touched page. Every request also passes through its accept in S_IDLE and
// S_DONE, which posts the result; a rejected request goes straight from
// accept to S_DONE.
`include "bitmap_page_allocator_top_assert.svh"
module bitmap_page_allocator_top #(
	parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bpa_pkg::rsp_t rsp
);
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW = AW + 5;
	localparam int CW = PW + 1;
	localparam logic [CW-1:0] TOTAL = CW'(MAP_WORDS) << 5;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EVAL  = 7'b0001000,
		S_MREAD = 7'b0010000,
		S_MEVAL = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [31:0]   mem [MAP_WORDS];
	logic [31:0]   rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata;
	logic [AW-1:0] clr_q;
	logic [2:0]    cmd_q;
	logic [CW-1:0] pos_q;      // page being examined or written
	logic [CW-1:0] end_q;      // one past last page to write
	logic [CW-1:0] run_q;
	logic [CW-1:0] need_q;
	logic          mark_used_q;
	bpa_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic [4:0]    bit_idx;
	logic [AW-1:0] word_idx;
	logic          bit_used;
	logic [4:0]    lz;
	logic [1:0]    acc_status;
	state_t        acc_state;
	logic [2:0]    acc_cmd;
	logic [31:0]   span_end;

	assign bit_idx  = pos_q[4:0];
	assign word_idx = pos_q[PW-1:5];
	assign bit_used = rdata_q[bit_idx];
	assign span_end = 32'(req.page) + 32'(req.count);

	always_comb begin
		lz = 5'd31;
		for (int n = 30; n >= 0; n--) begin
			if (!rdata_q[n]) lz = 5'(n);
		end
	end

	// decode the incoming request: first state, command and early status
	always_comb begin
		acc_status = bpa_pkg::ST_OK;
		acc_state  = S_DONE;
		acc_cmd    = req.cmd;
		unique case (req.cmd) inside
			bpa_pkg::CMD_ALLOC_ONE: acc_state = S_READ;
			bpa_pkg::CMD_ALLOC_RUN: begin
				if (req.count == 16'd1) begin
					acc_cmd   = bpa_pkg::CMD_ALLOC_ONE;
					acc_state = S_READ;
				end else if (req.count == 16'd0) begin
					acc_status = bpa_pkg::ST_BAD;
				end else if (32'(req.count) > 32'(TOTAL)) begin
					acc_status = bpa_pkg::ST_NOSPACE;
				end else begin
					acc_state = S_READ;
				end
			end
			bpa_pkg::CMD_FREE, bpa_pkg::CMD_MARK_FREE, bpa_pkg::CMD_MARK_USED: begin
				if (32'(req.page) >= 32'(TOTAL) ||
						(req.cmd != bpa_pkg::CMD_FREE && req.count == 16'd0))
					acc_status = bpa_pkg::ST_BAD;
				else
					acc_state = S_MREAD;
			end
			default: acc_status = bpa_pkg::ST_BAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign raddr     = word_idx;
	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		waddr = word_idx;
		wdata = rdata_q;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = bpa_pkg::ALL_USED;
			end
			S_EVAL: begin
				if (cmd_q == bpa_pkg::CMD_ALLOC_ONE && rdata_q != bpa_pkg::ALL_USED) begin
					we = 1'b1;
					wdata = rdata_q | (32'd1 << lz);
				end
			end
			S_MEVAL: begin
				we = 1'b1;
				wdata = rdata_q;
				wdata[bit_idx] = mark_used_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAP_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid && req_ready) begin
						cmd_q       <= acc_cmd;
						run_q       <= '0;
						rsp_q       <= '{status: acc_status, page_out: '0};
						state_q     <= acc_state;
						need_q      <= CW'(req.count);
						mark_used_q <= (req.cmd == bpa_pkg::CMD_MARK_USED);
						if (req.cmd == bpa_pkg::CMD_ALLOC_ONE ||
								req.cmd == bpa_pkg::CMD_ALLOC_RUN)
							pos_q <= '0;
						else
							pos_q <= CW'(req.page);
						if (req.cmd == bpa_pkg::CMD_FREE)
							end_q <= CW'(req.page) + 1'b1;
						else if (span_end > 32'(TOTAL))
							end_q <= TOTAL;
						else
							end_q <= CW'(span_end);
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (cmd_q == bpa_pkg::CMD_ALLOC_ONE) begin
						if (rdata_q != bpa_pkg::ALL_USED) begin
							rsp_q.page_out <= 15'({word_idx, lz});
							state_q <= S_DONE;
						end else if (word_idx == AW'(MAP_WORDS - 1)) begin
							rsp_q.status <= bpa_pkg::ST_NOSPACE;
							state_q <= S_DONE;
						end else begin
							pos_q <= pos_q + CW'(32);
							state_q <= S_READ;
						end
					end else begin
						// run search: one page per cycle, reread on word change
						if (!bit_used && run_q + 1'b1 == need_q) begin
							pos_q <= pos_q + 1'b1 - need_q;
							end_q <= pos_q + 1'b1;
							mark_used_q <= 1'b1;
							rsp_q.page_out <= 15'(pos_q + 1'b1 - need_q);
							state_q <= S_MREAD;
						end else if (pos_q == TOTAL - 1'b1) begin
							rsp_q.status <= bpa_pkg::ST_NOSPACE;
							state_q <= S_DONE;
						end else begin
							run_q <= bit_used ? '0 : run_q + 1'b1;
							pos_q <= pos_q + 1'b1;
							if (bit_idx == 5'd31) state_q <= S_READ;
						end
					end
				end
				S_MREAD: state_q <= S_MEVAL;
				S_MEVAL: begin
					// write-back lands before the next read of the same word
					pos_q <= pos_q + 1'b1;
					if (pos_q + 1'b1 == end_q) state_q <= S_DONE;
					else state_q <= S_MREAD;
				end
				S_DONE: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BPA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !req_ready)
	`BPA_ASSERT_NEXT(a_done_gives_rsp, clk, arst_n, state_q == S_DONE, rsp_valid)
	`BPA_ASSERT_IMP(a_ok_page_zero, clk, arst_n,
		rsp_valid && rsp.status != bpa_pkg::ST_OK, rsp.page_out == '0)
endmodule
